// File: sv/bmg_pkg.sv
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared types, constants and field arithmetic for the Berlekamp-Massey unit.
// ----------------------------------------------------------------------------
package bmg_pkg;

    localparam int unsigned ELEM_W     = 13;
    localparam int unsigned IDX_W      = 8;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned FPOLY_W    = 14;
    localparam int unsigned CFG_DATA_W = 14;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned OP_W       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE  = 1'b1;

    localparam logic [FPOLY_W-1:0] FPOLY_RESET = 14'd8219;
    localparam logic [LEN_W-1:0]   LEN_MAX     = 8'd255;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 4'd1;
    localparam logic [OP_W-1:0] OP_WSYN  = 4'd2;
    localparam logic [OP_W-1:0] OP_DISC  = 4'd3;
    localparam logic [OP_W-1:0] OP_DEC   = 4'd4;
    localparam logic [OP_W-1:0] OP_UPD   = 4'd5;
    localparam logic [OP_W-1:0] OP_FIN   = 4'd6;
    localparam logic [OP_W-1:0] OP_RD0   = 4'd7;
    localparam logic [OP_W-1:0] OP_INVI  = 4'd8;
    localparam logic [OP_W-1:0] OP_INV   = 4'd9;
    localparam logic [OP_W-1:0] OP_RDC   = 4'd10;
    localparam logic [OP_W-1:0] OP_COEF  = 4'd11;
    localparam logic [OP_W-1:0] OP_EMIT  = 4'd12;

    typedef struct packed {
        logic              accept;
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  cnt;
    } bmg_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
        logic mode;
    } bmg_status_t;

    // shift-and-add multiply in GF(2^m), reduced by the low m bits of taps
    function automatic logic [ELEM_W-1:0] gf_mul(
        input logic [ELEM_W-1:0] a,
        input logic [ELEM_W-1:0] b,
        input logic [ELEM_W-1:0] taps,
        input int unsigned       m
    );
        logic [ELEM_W:0]   r;
        logic [ELEM_W:0]   mask;
        r    = '0;
        mask = (ELEM_W+1)'((15'(1) << m) - 15'(1));
        for (int i = ELEM_W - 1; i >= 0; i--) begin
            if (i < int'(m)) begin
                r = r << 1;
                if (r[m])
                    r = (r & mask) ^ {1'b0, taps & mask[ELEM_W-1:0]};
                if (b[i])
                    r = r ^ ({1'b0, a} & mask);
            end
        end
        return r[ELEM_W-1:0];
    endfunction

endpackage

// File: sv/bmg_in_if.sv
// ----------------------------------------------------------------------------
// bmg_in_if
// Input channel: one push or read request per word.
// ----------------------------------------------------------------------------
interface bmg_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [12:0] syndrome;
    logic [7:0]  coef_index;

    modport source (output valid, mode, syndrome, coef_index, input ready);
    modport sink   (input valid, mode, syndrome, coef_index, output ready);
endinterface

// File: sv/bmg_out_if.sv
// ----------------------------------------------------------------------------
// bmg_out_if
// Result channel: one word per accepted request.
// ----------------------------------------------------------------------------
interface bmg_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] coefficient;
    logic [7:0]  locator_length;
    logic        done_res;

    modport source (output valid, coefficient, locator_length, done_res, input ready);
    modport sink   (input valid, coefficient, locator_length, done_res, output ready);
endinterface

// File: sv/bmg_ctrl.sv
// ----------------------------------------------------------------------------
// bmg_ctrl
// Sequencer: clearing sweep, discrepancy and update sweeps, inversion steps.
// ----------------------------------------------------------------------------
module bmg_ctrl #(
    parameter int unsigned FIELD_BITS = 13,
    parameter int unsigned CORRECT_T  = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bmg_pkg::bmg_status_t status,
    output bmg_pkg::bmg_cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DISP   = 4'd2;
    localparam logic [3:0] ST_WSYN   = 4'd3;
    localparam logic [3:0] ST_DISC   = 4'd4;
    localparam logic [3:0] ST_DDRAIN = 4'd5;
    localparam logic [3:0] ST_DEC    = 4'd6;
    localparam logic [3:0] ST_UPD    = 4'd7;
    localparam logic [3:0] ST_UDRAIN = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;
    localparam logic [3:0] ST_RD0    = 4'd10;
    localparam logic [3:0] ST_INVI   = 4'd11;
    localparam logic [3:0] ST_INV    = 4'd12;
    localparam logic [3:0] ST_RDC    = 4'd13;
    localparam logic [3:0] ST_COEF   = 4'd14;
    localparam logic [3:0] ST_EMIT   = 4'd15;

    localparam logic [bmg_pkg::CNT_W-1:0] CNT_LAST = bmg_pkg::CNT_W'(CORRECT_T);
    localparam logic [bmg_pkg::CNT_W-1:0] INV_LAST = bmg_pkg::CNT_W'(FIELD_BITS - 1);
    localparam logic [bmg_pkg::CNT_W-1:0] DRAIN_LAST = bmg_pkg::CNT_W'(1);

    logic [3:0]                 state_reg, state_next;
    logic [bmg_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.op     = bmg_pkg::OP_NONE;
        cmd.cnt    = cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.op = bmg_pkg::OP_CLEAR;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_WSYN : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                cnt_next = '0;
                if (status.mode)
                    state_next = ST_RD0;
                else if (status.done) begin
                    // a push after a finished run starts over from reset values
                    pend_next  = 1'b1;
                    state_next = ST_CLEAR;
                end else
                    state_next = ST_WSYN;
            end
            ST_WSYN: begin
                cmd.op     = bmg_pkg::OP_WSYN;
                cnt_next   = '0;
                state_next = ST_DISC;
            end
            ST_DISC: begin
                cmd.op = bmg_pkg::OP_DISC;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DDRAIN;
                end else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DDRAIN: begin
                if (cnt_reg == DRAIN_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DEC;
                end else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DEC: begin
                cmd.op     = bmg_pkg::OP_DEC;
                cnt_next   = '0;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.op = bmg_pkg::OP_UPD;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_UDRAIN;
                end else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_UDRAIN: begin
                if (cnt_reg == DRAIN_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_FIN: begin
                cmd.op     = bmg_pkg::OP_FIN;
                state_next = ST_EMIT;
            end
            ST_RD0: begin
                cmd.op     = bmg_pkg::OP_RD0;
                state_next = ST_INVI;
            end
            ST_INVI: begin
                cmd.op     = bmg_pkg::OP_INVI;
                cnt_next   = '0;
                state_next = ST_INV;
            end
            ST_INV: begin
                cmd.op = bmg_pkg::OP_INV;
                if (cnt_reg == INV_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_RDC;
                end else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_RDC: begin
                cmd.op     = bmg_pkg::OP_RDC;
                state_next = ST_COEF;
            end
            ST_COEF: begin
                cmd.op     = bmg_pkg::OP_COEF;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = bmg_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/bmg_dp.sv
// ----------------------------------------------------------------------------
// bmg_dp
// Datapath: polynomial and syndrome memories, two field multipliers,
// discrepancy accumulator, length tracking and the output register.
// ----------------------------------------------------------------------------
module bmg_dp #(
    parameter int unsigned FIELD_BITS = 13,
    parameter int unsigned CORRECT_T  = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmg_pkg::bmg_cmd_t                   cmd,
    output bmg_pkg::bmg_status_t                status,
    input  logic                                wr_en,
    input  logic [bmg_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0]      wr_data,
    input  logic                                mode,
    input  logic [bmg_pkg::ELEM_W-1:0]          syndrome,
    input  logic [bmg_pkg::IDX_W-1:0]           coef_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bmg_pkg::ELEM_W-1:0]          coefficient,
    output logic [bmg_pkg::LEN_W-1:0]           locator_length,
    output logic                                done_res
);

    localparam int unsigned NCOEF = CORRECT_T + 1;
    localparam int unsigned AW    = $clog2(NCOEF);
    localparam int unsigned SD    = 2 * CORRECT_T;
    localparam int unsigned SAW   = (SD > 2) ? $clog2(SD) : 1;
    localparam int unsigned NW    = $clog2(SD + 1);
    localparam int unsigned EW    = bmg_pkg::ELEM_W;
    localparam logic [EW-1:0] ELEM_MASK = EW'((15'd1 << FIELD_BITS) - 15'd1);
    localparam logic [NW-1:0] N_DONE    = NW'(SD);
    localparam logic [bmg_pkg::IDX_W-1:0] IDX_MAX = bmg_pkg::IDX_W'(CORRECT_T);

    logic [EW-1:0] c_mem [NCOEF];
    logic [EW-1:0] b_mem [NCOEF];
    logic [EW-1:0] s_mem [SD];

    logic [bmg_pkg::FPOLY_W-1:0] fpoly_reg;
    logic                        norm_reg;
    logic                        mode_reg;
    logic [EW-1:0]               syn_reg;
    logic [bmg_pkg::IDX_W-1:0]   idx_reg;
    logic [NW-1:0]               n_reg;
    logic [bmg_pkg::LEN_W-1:0]   len_reg;
    logic [EW-1:0]               bd_reg, d_reg;
    logic                        swap_reg;
    logic [EW-1:0]               c_q, b_q, s_q;
    logic                        sz1_reg, v1_reg, k1_reg, v2_reg, k2_reg;
    logic [AW-1:0]               idx1_reg, idx2_reg;
    logic [EW-1:0]               pa_reg, pb_reg, nb_reg;
    logic [EW-1:0]               last_c_reg, last_b_reg;
    logic [EW-1:0]               r_reg, base_reg;
    logic                        oor_reg;
    logic [EW-1:0]               coef_reg;

    logic [EW-1:0]  taps;
    logic [AW-1:0]  c_addr;
    logic [9:0]     s_diff;
    logic [EW-1:0]  ma_x, ma_y, mb_x, mb_y, mul_a, mul_b;
    logic [9:0]     new_len;
    logic           is_disc, is_upd;

    assign taps    = fpoly_reg[EW-1:0] & ELEM_MASK;
    assign is_disc = cmd.op == bmg_pkg::OP_DISC;
    assign is_upd  = cmd.op == bmg_pkg::OP_UPD;
    assign s_diff  = 10'(n_reg) - 10'(cmd.cnt);
    assign new_len = 10'(n_reg) + 10'd1 - 10'(len_reg);

    always_comb begin
        case (cmd.op)
            bmg_pkg::OP_RD0: c_addr = '0;
            bmg_pkg::OP_RDC: c_addr = idx_reg[AW-1:0];
            default:         c_addr = cmd.cnt[AW-1:0];
        endcase
    end

    // multiplier operand selection: sweep stage first, then read path
    always_comb begin
        ma_x = c_q;
        ma_y = r_reg;
        mb_x = base_reg;
        mb_y = base_reg;
        if (v1_reg && !k1_reg) begin
            ma_x = c_q;
            ma_y = sz1_reg ? '0 : s_q;
        end else if (v1_reg && k1_reg) begin
            ma_x = bd_reg;
            ma_y = c_q;
            mb_x = d_reg;
            mb_y = b_q;
        end else if (cmd.op == bmg_pkg::OP_INV) begin
            ma_x = r_reg;
            ma_y = base_reg;
        end
    end

    assign mul_a = bmg_pkg::gf_mul(ma_x, ma_y, taps, FIELD_BITS);
    assign mul_b = bmg_pkg::gf_mul(mb_x, mb_y, taps, FIELD_BITS);

    // memories
    always_ff @(posedge clk) begin
        c_q <= c_mem[c_addr];
        b_q <= b_mem[c_addr];
        s_q <= s_mem[s_diff[SAW-1:0]];
        if (cmd.op == bmg_pkg::OP_CLEAR) begin
            c_mem[cmd.cnt[AW-1:0]] <= (cmd.cnt == '0) ? EW'(1) : '0;
            b_mem[cmd.cnt[AW-1:0]] <= (cmd.cnt == bmg_pkg::CNT_W'(1)) ? EW'(1) : '0;
        end else if (v2_reg && k2_reg) begin
            c_mem[idx2_reg] <= pa_reg ^ pb_reg;
            b_mem[idx2_reg] <= nb_reg;
        end
        if (cmd.op == bmg_pkg::OP_WSYN)
            s_mem[n_reg[SAW-1:0]] <= syn_reg & ELEM_MASK;
    end

    // payload and pipeline registers
    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            mode_reg <= mode;
            syn_reg  <= syndrome;
            idx_reg  <= coef_index;
        end
        sz1_reg  <= s_diff[9];
        idx1_reg <= cmd.cnt[AW-1:0];
        k1_reg   <= is_upd;
        if (v1_reg) begin
            pa_reg     <= mul_a;
            pb_reg     <= mul_b;
            // B shifts up one degree, taking old C on a swap
            nb_reg     <= (idx1_reg == '0) ? '0 : (swap_reg ? last_c_reg : last_b_reg);
            last_c_reg <= c_q;
            last_b_reg <= b_q;
            idx2_reg   <= idx1_reg;
            k2_reg     <= k1_reg;
        end
        if (cmd.op == bmg_pkg::OP_INVI) begin
            r_reg    <= EW'(1);
            base_reg <= c_q;
        end else if (cmd.op == bmg_pkg::OP_INV) begin
            // exponent 2^m-2: every bit set except bit 0
            if (cmd.cnt != '0)
                r_reg <= mul_a;
            base_reg <= mul_b;
        end
        if (cmd.op == bmg_pkg::OP_RDC)
            oor_reg <= idx_reg > IDX_MAX;
        if (cmd.op == bmg_pkg::OP_COEF)
            coef_reg <= oor_reg ? '0 : (norm_reg ? mul_a : c_q);
        if (cmd.op == bmg_pkg::OP_EMIT) begin
            coefficient    <= mode_reg ? coef_reg : '0;
            locator_length <= len_reg;
            done_res       <= n_reg == N_DONE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fpoly_reg <= bmg_pkg::FPOLY_RESET;
            norm_reg  <= 1'b1;
            n_reg     <= '0;
            len_reg   <= '0;
            bd_reg    <= EW'(1);
            d_reg     <= '0;
            swap_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                case (wr_index)
                    bmg_pkg::REG_FIELD_POLY: fpoly_reg <= wr_data;
                    bmg_pkg::REG_NORMALIZE:  norm_reg  <= wr_data[0];
                    default: ;
                endcase
            end
            v1_reg <= is_disc || is_upd;
            v2_reg <= v1_reg;
            case (cmd.op)
                bmg_pkg::OP_CLEAR: begin
                    n_reg   <= '0;
                    len_reg <= '0;
                    bd_reg  <= EW'(1);
                end
                bmg_pkg::OP_WSYN: d_reg <= '0;
                bmg_pkg::OP_DEC:
                    swap_reg <= (d_reg != '0) && (10'({len_reg, 1'b0}) <= 10'(n_reg));
                bmg_pkg::OP_FIN: begin
                    if (swap_reg) begin
                        len_reg <= (new_len > 10'(bmg_pkg::LEN_MAX)) ? bmg_pkg::LEN_MAX
                                                                      : new_len[7:0];
                        bd_reg  <= d_reg;
                    end
                    n_reg <= n_reg + 1'b1;
                end
                default: ;
            endcase
            if (v2_reg && !k2_reg)
                d_reg <= d_reg ^ pa_reg;
            if (cmd.op == bmg_pkg::OP_EMIT)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    assign status.done     = n_reg == N_DONE;
    assign status.out_free = !out_valid || out_ready;
    assign status.mode     = mode_reg;

endmodule

// File: sv/berlekamp_massey_gf2m_unit.sv
// ----------------------------------------------------------------------------
// berlekamp_massey_gf2m_unit
// Berlekamp-Massey key-equation solver over GF(2^m), one coefficient a cycle.
// ----------------------------------------------------------------------------
// A push word runs from acceptance to result through one sweep over the
// connection polynomial memory to form the discrepancy and one sweep to
// update C and B, each one coefficient per cycle through the single read
// port, plus pipeline drain and bookkeeping. A read word is dominated by the
// square-and-multiply inversion of the constant term. After reset, and before
// the first push after a finished run, a clearing pass rewrites both
// polynomial memories; configuration writes are taken at any time. One word
// is worked on at a time; a finished result waits in the output register
// while the next word is taken.
module berlekamp_massey_gf2m_unit #(
    parameter int unsigned FIELD_BITS = 13,
    parameter int unsigned CORRECT_T  = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bmg_in_if.sink                            item,
    bmg_out_if.source                         result,
    input  logic                              wr_en,
    input  logic [bmg_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0]    wr_data
);

    bmg_pkg::bmg_cmd_t    cmd;
    bmg_pkg::bmg_status_t status;
    logic                 in_ready;

    assign item.ready = in_ready;

    bmg_ctrl #(
        .FIELD_BITS (FIELD_BITS),
        .CORRECT_T  (CORRECT_T)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bmg_dp #(
        .FIELD_BITS (FIELD_BITS),
        .CORRECT_T  (CORRECT_T)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .mode           (item.mode),
        .syndrome       (item.syndrome),
        .coef_index     (item.coef_index),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .coefficient    (result.coefficient),
        .locator_length (result.locator_length),
        .done_res       (result.done_res)
    );

endmodule

// File: sv/bmg_checker.sv
// ----------------------------------------------------------------------------
// bmg_checker
// Port-level checks on the solver unit, bound to the top level.
// ----------------------------------------------------------------------------
module bmg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] out_coef,
    input logic [7:0]  out_len,
    input logic        out_done
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_coef) && $stable(out_len)
                                    && $stable(out_done))
        else $error("result word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while busy");

    // a new result only comes out of a busy period
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

endmodule

bind berlekamp_massey_gf2m_unit bmg_checker u_bmg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_coef  (result.coefficient),
    .out_len   (result.locator_length),
    .out_done  (result.done_res)
);
